// ----- rtl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define IHEX_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("ihex assertion failed");
`define IHEX_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define IHEX_ASSERT(lbl, clk, rst_n, prop)
`define IHEX_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ----- rtl/ihex_pkg.sv -----
package ihex_pkg;

	localparam int IHEX_RECORD_BYTES = 16;

	localparam logic [7:0] REC_TYPE_DATA = 8'h00;
	localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
	localparam logic [7:0] REC_TYPE_ELA  = 8'h04;
	localparam logic [7:0] ELA_LEN       = 8'h02;

	localparam logic [6:0] ASCII_COLON   = 7'h3A;
	localparam logic [6:0] ASCII_NL      = 7'h0A;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COLON,
		ST_CNT_H,
		ST_CNT_L,
		ST_ADH_H,
		ST_ADH_L,
		ST_ADL_H,
		ST_ADL_L,
		ST_TYP_H,
		ST_TYP_L,
		ST_PAY_H,
		ST_PAY_L,
		ST_SUM_H,
		ST_SUM_L,
		ST_NL
	} state_t;

	typedef enum logic [1:0] {CH_COLON, CH_HI, CH_LO, CH_NL} chr_t;

	typedef enum logic [2:0] {FLD_CNT, FLD_ADH, FLD_ADL, FLD_TYP, FLD_PAY, FLD_SUM} fld_t;

	typedef enum logic [1:0] {REC_DATA, REC_ELA, REC_EOF} rec_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic emit;
		logic rec_end;
		chr_t chr;
		fld_t fld;
	} ihex_cmd_t;

	typedef struct packed {
		logic has_rec;
		logic pay_empty;
		logic pay_last;
		logic more;
		logic slot_free;
	} ihex_sts_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] v;
		v = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_char = 7'h30 + v;
		end else begin
			hex_char = 7'h37 + v;
		end
	endfunction

endpackage

// ----- rtl/ihex_ram.sv -----
module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ihex_ctrl.sv -----
`include "assert_macros.svh"

module ihex_ctrl import ihex_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ihex_sts_t sts,
	output ihex_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && sts.has_rec) state_d = ST_COLON;
			ST_COLON: if (sts.slot_free) state_d = ST_CNT_H;
			ST_CNT_H: if (sts.slot_free) state_d = ST_CNT_L;
			ST_CNT_L: if (sts.slot_free) state_d = ST_ADH_H;
			ST_ADH_H: if (sts.slot_free) state_d = ST_ADH_L;
			ST_ADH_L: if (sts.slot_free) state_d = ST_ADL_H;
			ST_ADL_H: if (sts.slot_free) state_d = ST_ADL_L;
			ST_ADL_L: if (sts.slot_free) state_d = ST_TYP_H;
			ST_TYP_H: if (sts.slot_free) state_d = ST_TYP_L;
			ST_TYP_L: if (sts.slot_free) state_d = sts.pay_empty ? ST_SUM_H : ST_PAY_H;
			ST_PAY_H: if (sts.slot_free) state_d = ST_PAY_L;
			ST_PAY_L: if (sts.slot_free) state_d = sts.pay_last ? ST_SUM_H : ST_PAY_H;
			ST_SUM_H: if (sts.slot_free) state_d = ST_SUM_L;
			ST_SUM_L: if (sts.slot_free) state_d = ST_NL;
			ST_NL:    if (sts.slot_free) state_d = sts.more ? ST_COLON : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.in_ready = (state_q == ST_IDLE);
		cmd.accept   = in_valid && (state_q == ST_IDLE);
		cmd.emit     = sts.slot_free && (state_q != ST_IDLE);
		cmd.rec_end  = sts.slot_free && (state_q == ST_NL);
		cmd.chr      = CH_HI;
		cmd.fld      = FLD_CNT;
		unique case (state_q)
			ST_IDLE:  cmd.chr = CH_COLON;
			ST_COLON: cmd.chr = CH_COLON;
			ST_CNT_H: begin cmd.chr = CH_HI; cmd.fld = FLD_CNT; end
			ST_CNT_L: begin cmd.chr = CH_LO; cmd.fld = FLD_CNT; end
			ST_ADH_H: begin cmd.chr = CH_HI; cmd.fld = FLD_ADH; end
			ST_ADH_L: begin cmd.chr = CH_LO; cmd.fld = FLD_ADH; end
			ST_ADL_H: begin cmd.chr = CH_HI; cmd.fld = FLD_ADL; end
			ST_ADL_L: begin cmd.chr = CH_LO; cmd.fld = FLD_ADL; end
			ST_TYP_H: begin cmd.chr = CH_HI; cmd.fld = FLD_TYP; end
			ST_TYP_L: begin cmd.chr = CH_LO; cmd.fld = FLD_TYP; end
			ST_PAY_H: begin cmd.chr = CH_HI; cmd.fld = FLD_PAY; end
			ST_PAY_L: begin cmd.chr = CH_LO; cmd.fld = FLD_PAY; end
			ST_SUM_H: begin cmd.chr = CH_HI; cmd.fld = FLD_SUM; end
			ST_SUM_L: begin cmd.chr = CH_LO; cmd.fld = FLD_SUM; end
			ST_NL:    cmd.chr = CH_NL;
			default:  cmd.chr = CH_NL;
		endcase
	end

	`IHEX_ASSERT(a_nl_exit, clk, arst_n, (state_q == ST_NL && sts.slot_free) |=> (state_q == ST_IDLE || state_q == ST_COLON))
	`IHEX_ASSERT(a_typ_exit, clk, arst_n, (state_q == ST_TYP_L && sts.slot_free) |=> (state_q == ST_PAY_H || state_q == ST_SUM_H))
	`IHEX_ASSERT_MSG(a_stall_hold, clk, arst_n, (state_q != ST_IDLE && !sts.slot_free) |=> $stable(state_q), "state moved while output stalled")

endmodule

// ----- rtl/ihex_dp.sv -----
`include "assert_macros.svh"

module ihex_dp import ihex_pkg::*; #(
	parameter int RECORD_BYTES = IHEX_RECORD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ihex_cmd_t   cmd,
	output ihex_sts_t   sts,
	input  logic        in_op,
	input  logic [31:0] in_addr,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  out_char,
	output logic        out_last
);

	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CNT_W = $clog2(RECORD_BYTES + 1);

	logic [CNT_W-1:0] count_q, dlen_q, cnt_nx;
	logic [15:0]      start_low_q, cur_seg_q, seg;
	logic             fresh_q, pend_q;
	rec_t             kind_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       sum_q, fld_byte, ram_rdata;
	logic             first, need_ela, close, ram_we;
	logic             out_valid_q, out_last_q;
	logic [6:0]       out_char_q, chr_code;

	assign first    = (count_q == '0);
	assign seg      = in_addr[31:16];
	assign need_ela = first && (fresh_q || seg != cur_seg_q);
	assign cnt_nx   = count_q + CNT_W'(1);
	assign close    = (cnt_nx == CNT_W'(RECORD_BYTES)) || in_last;
	assign ram_we   = cmd.accept && !in_op;

	always_comb begin
		idx_d = idx_q;
		if (cmd.rec_end) begin
			idx_d = '0;
		end else if (cmd.emit && cmd.fld == FLD_PAY && cmd.chr == CH_LO) begin
			idx_d = idx_q + IDX_W'(1);
		end
	end

	ihex_ram #(
		.WIDTH(8),
		.DEPTH(RECORD_BYTES),
		.AW(IDX_W)
	) u_buf (
		.clk(clk),
		.we(ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(in_byte),
		.raddr(idx_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dlen_q      <= '0;
			start_low_q <= '0;
			cur_seg_q   <= '0;
			fresh_q     <= 1'b1;
			pend_q      <= 1'b0;
			kind_q      <= REC_DATA;
			idx_q       <= '0;
			sum_q       <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.accept) begin
				sum_q <= '0;
				if (in_op) begin
					kind_q  <= REC_EOF;
					pend_q  <= 1'b0;
					count_q <= '0;
					fresh_q <= 1'b1;
				end else begin
					if (first) begin
						start_low_q <= in_addr[15:0];
					end
					if (need_ela) begin
						cur_seg_q <= seg;
					end
					kind_q  <= need_ela ? REC_ELA : REC_DATA;
					pend_q  <= need_ela && close;
					dlen_q  <= cnt_nx;
					count_q <= close ? '0 : cnt_nx;
					fresh_q <= in_last ? 1'b1 : (need_ela ? 1'b0 : fresh_q);
				end
			end else if (cmd.rec_end) begin
				kind_q <= REC_DATA;
				pend_q <= 1'b0;
				sum_q  <= '0;
			end else if (cmd.emit && cmd.chr == CH_LO && cmd.fld != FLD_SUM) begin
				sum_q <= sum_q + fld_byte;
			end
		end
	end

	always_comb begin
		fld_byte = 8'h00;
		case (cmd.fld)
			FLD_CNT: begin
				case (kind_q)
					REC_ELA: fld_byte = ELA_LEN;
					REC_EOF: fld_byte = 8'h00;
					default: fld_byte = 8'(dlen_q);
				endcase
			end
			FLD_ADH: fld_byte = (kind_q == REC_DATA) ? start_low_q[15:8] : 8'h00;
			FLD_ADL: fld_byte = (kind_q == REC_DATA) ? start_low_q[7:0] : 8'h00;
			FLD_TYP: begin
				case (kind_q)
					REC_ELA: fld_byte = REC_TYPE_ELA;
					REC_EOF: fld_byte = REC_TYPE_EOF;
					default: fld_byte = REC_TYPE_DATA;
				endcase
			end
			FLD_PAY: begin
				if (kind_q == REC_ELA) begin
					fld_byte = idx_q[0] ? cur_seg_q[7:0] : cur_seg_q[15:8];
				end else begin
					fld_byte = ram_rdata;
				end
			end
			FLD_SUM: fld_byte = 8'h00 - sum_q;
			default: fld_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.chr)
			CH_COLON: chr_code = ASCII_COLON;
			CH_HI:    chr_code = hex_char(fld_byte[7:4]);
			CH_LO:    chr_code = hex_char(fld_byte[3:0]);
			default:  chr_code = ASCII_NL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= chr_code;
			out_last_q <= (cmd.chr == CH_NL) && !pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	always_comb begin
		sts.has_rec   = in_op || need_ela || close;
		sts.pay_empty = (kind_q == REC_EOF);
		sts.pay_last  = (kind_q == REC_ELA) ? idx_q[0] :
			((CNT_W'(idx_q) + CNT_W'(1)) == dlen_q);
		sts.more      = pend_q;
		sts.slot_free = !out_valid_q || out_ready;
	end

	`IHEX_ASSERT(a_count_range, clk, arst_n, count_q < CNT_W'(RECORD_BYTES))
	`IHEX_ASSERT(a_pend_ela, clk, arst_n, pend_q |-> kind_q == REC_ELA)
	`IHEX_ASSERT_MSG(a_last_nl, clk, arst_n, (out_valid_q && out_last_q) |-> out_char_q == ASCII_NL, "final char is not newline")

endmodule

// ----- rtl/intel_hex_record_encoder.sv -----
// Intel HEX encoder: accepts one memory byte (with its absolute address) or an end-of-file
// request and streams the resulting hex text, one ASCII character per output beat, with
// tlast on the final character that request causes. Bytes collect into data records of
// up to RECORD_BYTES bytes; a record closes when full or on tlast (end of region). A
// type 04 record precedes a record that starts a region or a new 64K segment. A request
// that only buffers a byte produces no output. The block takes one request at a time: a
// request is taken only when the character sequencer is idle, and the sequencer sends one
// character per cycle unless m_axis_tready stalls it, so a new request waits until the
// sequencer has sent every record that the last request closes.
module intel_hex_record_encoder import ihex_pkg::*; #(
	parameter int RECORD_BYTES = IHEX_RECORD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // byte_address[31:0], data_byte[39:32]
	input  logic        s_axis_tuser,  // op
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_char[6:0], zero[7]
	output logic        m_axis_tlast
);

	ihex_cmd_t  cmd;
	ihex_sts_t  sts;
	logic [6:0] out_char;

	ihex_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.sts(sts),
		.cmd(cmd)
	);

	ihex_dp #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_op(s_axis_tuser),
		.in_addr(s_axis_tdata[31:0]),
		.in_byte(s_axis_tdata[39:32]),
		.in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_char(out_char),
		.out_last(m_axis_tlast)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = {1'b0, out_char};

endmodule

// ----- tb/intel_hex_record_encoder_tb.sv -----
module intel_hex_record_encoder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ihex_pkg::*;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOF  = 1'b1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER = 100;
	localparam int DRAIN_CYCLES = 100;
	localparam string HEX_DIGITS = "0123456789ABCDEF";

	typedef struct {
		logic        op;
		logic [31:0] addr;
		logic [7:0]  data;
		logic        last;
	} mem_req_t;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} text_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // byte_address[31:0], data_byte[39:32]
	logic        s_axis_tuser = 1'b0;  // op
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // out_char[6:0], zero[7]
	logic        m_axis_tlast;

	mem_req_t   pending_items[$];
	text_beat_t expected_text[$];
	mem_req_t   tx_item;

	int total_items = 0;
	int items_accepted = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// encoder image kept by the predictor
	logic [7:0]  rec_bytes[16];
	int          fill_count = 0;
	logic [15:0] rec_low = '0;
	logic [15:0] cur_seg = '0;
	bit          seg_fresh = 1'b1;

	wire quiet = (items_accepted >= 60 && items_accepted < 90) ||
		(items_accepted + 40 >= total_items);

	intel_hex_record_encoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic mem_req_t make_req(logic op, logic [31:0] addr, logic [7:0] data,
			logic last);
		mem_req_t r;
		r.op = op;
		r.addr = addr;
		r.data = data;
		r.last = last;
		return r;
	endfunction

	function automatic void push_char(logic [6:0] ch);
		text_beat_t b;
		b.ch = ch;
		b.last = 1'b0;
		expected_text.push_back(b);
	endfunction

	function automatic void push_hex(logic [7:0] v);
		push_char(7'(HEX_DIGITS[v[7:4]]));
		push_char(7'(HEX_DIGITS[v[3:0]]));
	endfunction

	function automatic void encode_record(logic [7:0] rtype, logic [15:0] addr, int len,
			logic [7:0] pay[16]);
		logic [7:0] sum;
		sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
		push_char(ASCII_COLON);
		push_hex(8'(len));
		push_hex(addr[15:8]);
		push_hex(addr[7:0]);
		push_hex(rtype);
		for (int k = 0; k < len; k++) begin
			push_hex(pay[k]);
			sum = sum + pay[k];
		end
		push_hex(8'h00 - sum);
		push_char(ASCII_NL);
	endfunction

	function automatic void predict_item(logic op, logic [31:0] addr, logic [7:0] data,
			logic last);
		int prev_size;
		logic [7:0] ela[16];
		prev_size = expected_text.size();
		if (op == OP_EOF) begin
			encode_record(REC_TYPE_EOF, 16'h0000, 0, rec_bytes);
			fill_count = 0;
			seg_fresh = 1'b1;
		end else begin
			if (fill_count == 0) begin
				if (seg_fresh || addr[31:16] != cur_seg) begin
					ela = rec_bytes;
					ela[0] = addr[31:24];
					ela[1] = addr[23:16];
					encode_record(REC_TYPE_ELA, 16'h0000, int'(ELA_LEN), ela);
					cur_seg = addr[31:16];
					seg_fresh = 1'b0;
				end
				rec_low = addr[15:0];
			end
			rec_bytes[fill_count] = data;
			fill_count++;
			if (fill_count >= IHEX_RECORD_BYTES || last) begin
				encode_record(REC_TYPE_DATA, rec_low, fill_count, rec_bytes);
				fill_count = 0;
			end
			if (last)
				seg_fresh = 1'b1;
		end
		if (expected_text.size() > prev_size)
			expected_text[expected_text.size() - 1].last = 1'b1;
	endfunction

	function automatic void report_mismatch(string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			tx_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_items.size() != 0) begin
				tx_item = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {tx_item.data, tx_item.addr};
				s_axis_tuser <= tx_item.op;
				s_axis_tlast <= tx_item.last;
				if (!quiet && $urandom_range(0, 7) == 0)
					tx_gap <= $urandom_range(1, 19);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output side ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap <= 0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0)
				rx_gap <= $urandom_range(1, 19);
		end
	end

	// one long output stall so the encoder backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// predictor and text checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_accepted <= 0;
			fill_count = 0;
			rec_low = '0;
			cur_seg = '0;
			seg_fresh = 1'b1;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32],
					s_axis_tlast);
				items_accepted <= items_accepted + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected char tdata=%02h tlast=%0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					if (m_axis_tdata != {1'b0, expected_text[0].ch})
						report_mismatch($sformatf("char expected %02h actual %02h",
							{1'b0, expected_text[0].ch}, m_axis_tdata));
					if (m_axis_tlast != expected_text[0].last)
						report_mismatch($sformatf("tlast expected %0b actual %0b",
							expected_text[0].last, m_axis_tlast));
					void'(expected_text.pop_front());
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no request or char moved for %0d cycles", idle_cycles);
			$display("intel_hex_record_encoder verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int len;
		bit close;
		logic [31:0] base;

		// directed part
		pending_items.push_back(make_req(OP_EOF, 32'h0, 8'h0, 1'b0));
		pending_items.push_back(make_req(OP_DATA, 32'h0000_0000, 8'h00, 1'b1));
		pending_items.push_back(make_req(OP_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		// later byte address ignored
		pending_items.push_back(make_req(OP_DATA, 32'h0005_0010, 8'hA5, 1'b0));
		pending_items.push_back(make_req(OP_DATA, 32'h1234_5678, 8'h5A, 1'b1));
		// eof drops the open record, its other fields ignored
		pending_items.push_back(make_req(OP_DATA, 32'h0002_0010, 8'h11, 1'b0));
		pending_items.push_back(make_req(OP_EOF, 32'hDEAD_BEEF, 8'hC3, 1'b1));
		pending_items.push_back(make_req(OP_DATA, 32'h0002_0020, 8'h77, 1'b1));
		// full record crossing a segment boundary
		for (int i = 0; i < 16; i++)
			pending_items.push_back(make_req(OP_DATA, 32'h0002_FFF8 + i, 8'(i * 17), 1'b0));
		pending_items.push_back(make_req(OP_DATA, 32'h0002_ABCD, 8'h3C, 1'b1));

		// random regions
		while (pending_items.size() < 249) begin
			if ($urandom_range(0, 11) == 0) begin
				pending_items.push_back(make_req(OP_EOF, $urandom, 8'($urandom),
					1'($urandom)));
			end else begin
				if ($urandom_range(0, 2) == 0)
					base = {16'($urandom), 16'hFFFF - 16'($urandom_range(0, 20))};
				else
					base = $urandom;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 20);
				close = ($urandom_range(0, 5) != 0);
				for (int i = 0; i < len && pending_items.size() < 249; i++)
					pending_items.push_back(make_req(OP_DATA,
						($urandom_range(0, 9) == 0) ? $urandom : base + i,
						8'($urandom), close && i == len - 1));
			end
		end
		pending_items.push_back(make_req(OP_EOF, 32'h0, 8'h0, 1'b0));
		total_items = pending_items.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < total_items)
			@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_text.size() == 0) begin
			$display("intel_hex_record_encoder verification clean");
		end else begin
			$display("intel_hex_record_encoder verification failed");
		end
		$finish;
	end

endmodule
